FILE: rtl/core/btbox_pkg.sv
// Package for the bisection tree box lookup: coordinate and walk types,
// the per-level split axis table and configuration register indexes.
// No dependencies.
package btbox_pkg;

  // Widths fixed by the interface
  localparam int unsigned CoordW = 32;
  localparam int unsigned NodeW  = 21;
  localparam int unsigned DepthW = 5;
  localparam int unsigned AxisTableLen = 21;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [NodeW-1:0]         node_idx_t;
  typedef logic [DepthW-1:0]        depth_t;
  typedef logic [1:0]               axis_t;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_WORLD_MIN_X = 3'd0;
  localparam cfg_idx_t REG_WORLD_MIN_Y = 3'd1;
  localparam cfg_idx_t REG_WORLD_MIN_Z = 3'd2;
  localparam cfg_idx_t REG_WORLD_MAX_X = 3'd3;
  localparam cfg_idx_t REG_WORLD_MAX_Y = 3'd4;
  localparam cfg_idx_t REG_WORLD_MAX_Z = 3'd5;

  // Axis codes
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  // Split axis for each tree level
  localparam axis_t SPLIT_AXIS [AxisTableLen] = '{
    AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z,
    AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z,
    AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_Z
  };

  // Walk state carried down the pipeline with each box
  typedef struct packed {
    logic              done;
    node_idx_t         node;
    depth_t            depth;
    logic [2:0][CoordW-1:0] lo;
    logic [2:0][CoordW-1:0] hi;
    logic [2:0][CoordW-1:0] bmin;
    logic [2:0][CoordW-1:0] bmax;
  } walk_t;

endpackage

FILE: rtl/core/bisection_tree_box_node_lookup.sv
// Top level of the bisection tree box lookup: config registers, the
// per-level pipeline and the result port. Depends on btbox_pkg, btbox_level.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | box_min_x..z, box_max_x..z
//   out_    | output    | out_valid/out_stall| node_index, node_depth
//   cfg_    | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One box enters per cycle while the result port is not stalled; its result passes
// the capture stage, then one stage per tree level, before it is offered.
// rst_n (synchronous) clears all stage valid bits and world bounds to 0.
// A stalled result freezes the whole pipeline; in_stall follows it.
module bisection_tree_box_node_lookup import btbox_pkg::*; #(
  parameter int unsigned LEVELS = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  // config write port
  input  logic            cfg_wr_en,
  input  cfg_idx_t        cfg_index,
  input  logic [CoordW-1:0] cfg_data,
  // box input
  input  logic            in_valid,
  output logic            in_stall,
  input  coord_t          in_box_min_x,
  input  coord_t          in_box_min_y,
  input  coord_t          in_box_min_z,
  input  coord_t          in_box_max_x,
  input  coord_t          in_box_max_y,
  input  coord_t          in_box_max_z,
  // node result
  output logic            out_valid,
  input  logic            out_stall,
  output node_idx_t       out_node_index,
  output depth_t          out_node_depth
);

  logic [2:0][CoordW-1:0] world_min_r;
  logic [2:0][CoordW-1:0] world_max_r;

  logic [LEVELS:0] valid_r;
  walk_t           walk_r   [LEVELS+1];
  walk_t           walk_nxt [LEVELS];
  walk_t           walk_in_nxt;
  logic            adv;

  // World bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_min_r <= '0;
      world_max_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WORLD_MIN_X: world_min_r[0] <= cfg_data;
        REG_WORLD_MIN_Y: world_min_r[1] <= cfg_data;
        REG_WORLD_MIN_Z: world_min_r[2] <= cfg_data;
        REG_WORLD_MAX_X: world_max_r[0] <= cfg_data;
        REG_WORLD_MAX_Y: world_max_r[1] <= cfg_data;
        REG_WORLD_MAX_Z: world_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves unless the result is held
  assign adv      = !(valid_r[LEVELS] && out_stall);
  assign in_stall = !adv;

  // Capture stage: box plus root cell
  always_comb begin
    walk_in_nxt       = '0;
    walk_in_nxt.lo    = world_min_r;
    walk_in_nxt.hi    = world_max_r;
    walk_in_nxt.bmin  = {in_box_min_z, in_box_min_y, in_box_min_x};
    walk_in_nxt.bmax  = {in_box_max_z, in_box_max_y, in_box_max_x};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[LEVELS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      walk_r[0] <= walk_in_nxt;
    end
  end

  // One stage per tree level
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    btbox_level #(
      .LEVEL(k)
    ) u_level (
      .walk_in (walk_r[k]),
      .walk_out(walk_nxt[k])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        walk_r[k+1] <= walk_nxt[k];
      end
    end
  end

  // Result port
  assign out_valid      = valid_r[LEVELS];
  assign out_node_index = walk_r[LEVELS].node;
  assign out_node_depth = walk_r[LEVELS].depth;

`ifndef SYNTHESIS
  // Depth never passes the tree height
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_node_depth <= depth_t'(LEVELS)))
    else $error("node depth beyond tree height");

  // Node index lies on the level given by the depth
  a_node_on_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((({1'b0, out_node_index} + 22'd1) >> out_node_depth) == 22'd1))
    else $error("node index not on reported level");

  // Input is held off only by a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A held result stays valid in the next cycle
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result dropped");
`endif

endmodule

FILE: rtl/core/btbox_level.sv
// One tree level of the box walk: cell midpoint on the level's axis and
// the descend / straddle decision. Depends on btbox_pkg.
module btbox_level import btbox_pkg::*; #(
  parameter int unsigned LEVEL = 0
) (
  input  walk_t walk_in,
  output walk_t walk_out
);

  localparam axis_t Ax = SPLIT_AXIS[LEVEL];

  logic [CoordW:0]   sum;
  logic [CoordW-1:0] split;
  logic              go_lower;
  logic              straddle;

  // floor((lo + hi) / 2) at 33 bits
  assign sum   = {walk_in.lo[Ax][CoordW-1], walk_in.lo[Ax]}
               + {walk_in.hi[Ax][CoordW-1], walk_in.hi[Ax]};
  assign split = sum[CoordW:1];

  assign go_lower = $signed(walk_in.bmax[Ax]) <= $signed(split);
  assign straddle = $signed(walk_in.bmin[Ax]) <  $signed(split);

  // Descend into a child or stop where the box straddles the split
  always_comb begin
    walk_out = walk_in;
    if (!walk_in.done) begin
      if (go_lower) begin
        walk_out.node   = {walk_in.node[NodeW-2:0], 1'b0} + node_idx_t'(2);
        walk_out.hi[Ax] = split;
        walk_out.depth  = walk_in.depth + depth_t'(1);
      end else if (straddle) begin
        walk_out.done = 1'b1;
      end else begin
        walk_out.node   = {walk_in.node[NodeW-2:0], 1'b0} + node_idx_t'(1);
        walk_out.lo[Ax] = split;
        walk_out.depth  = walk_in.depth + depth_t'(1);
      end
    end
  end

endmodule

FILE: tb/sv/bisection_tree_box_node_lookup_test.sv
`timescale 1ns / 1ps
// Testbench for bisection_tree_box_node_lookup: random and corner-case query boxes against
// a behavioral tree walk, under several world bound settings. Depends on btbox_pkg.
module bisection_tree_box_node_lookup_test;
  import btbox_pkg::*;

  localparam int unsigned NUM_LEVELS = 20;
  localparam coord_t      C_NEG      = 32'sh8000_0000;
  localparam coord_t      C_POS      = 32'sh7FFF_FFFF;

  // One query box; idle_ok allows a sender gap before it and receiver stalls while it is out
  typedef struct packed {
    logic [2:0][CoordW-1:0] mn;
    logic [2:0][CoordW-1:0] mx;
    logic                   idle_ok;
  } box_t;

  typedef struct packed {
    node_idx_t node;
    depth_t    depth;
  } node_hit_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  cfg_idx_t  cfg_index = REG_WORLD_MIN_X;
  logic [CoordW-1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  coord_t    in_box_min_x = '0;
  coord_t    in_box_min_y = '0;
  coord_t    in_box_min_z = '0;
  coord_t    in_box_max_x = '0;
  coord_t    in_box_max_y = '0;
  coord_t    in_box_max_z = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  node_idx_t out_node_index;
  depth_t    out_node_depth;

  // Shadow of the world bound registers
  coord_t world_lo [3] = '{default: '0};
  coord_t world_hi [3] = '{default: '0};

  box_t      pending_boxes [$];
  node_hit_t expected_hits [$];
  int        boxes_issued = 0;
  int        hits_checked = 0;
  int        mismatches = 0;

  // Driver and monitor state
  box_t cur_box = '0;
  int   gap_left = 0;
  bit   gap_done = 1'b0;
  bit   idle_phase = 1'b0;
  int   stall_left = 0;
  bit   stall_done = 1'b0;

  bisection_tree_box_node_lookup #(
    .LEVELS(NUM_LEVELS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_box_min_x   (in_box_min_x),
    .in_box_min_y   (in_box_min_y),
    .in_box_min_z   (in_box_min_z),
    .in_box_max_x   (in_box_max_x),
    .in_box_max_y   (in_box_max_y),
    .in_box_max_z   (in_box_max_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_node_index (out_node_index),
    .out_node_depth (out_node_depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the implicit tree: midpoint split per level, descend while the box fits one half
  function automatic node_hit_t walk_tree(box_t b);
    coord_t          lo [3];
    coord_t          hi [3];
    coord_t          bmin [3];
    coord_t          bmax [3];
    logic [CoordW:0] sum;
    coord_t          split;
    axis_t           ax;
    node_hit_t       hit;
    bit              stopped;
    hit = '0;
    stopped = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lo[a] = world_lo[a];
      hi[a] = world_hi[a];
      bmin[a] = b.mn[a];
      bmax[a] = b.mx[a];
    end
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
      if (!stopped) begin
        ax = SPLIT_AXIS[lvl];
        // floor((lo + hi) / 2) at 33 bits
        sum = {lo[ax][CoordW-1], lo[ax]} + {hi[ax][CoordW-1], hi[ax]};
        split = sum[CoordW:1];
        if (bmax[ax] <= split) begin
          hit.node = node_idx_t'(hit.node * 2 + 2);
          hi[ax] = split;
          hit.depth = hit.depth + 1'b1;
        end else if (bmin[ax] < split) begin
          stopped = 1'b1;
        end else begin
          hit.node = node_idx_t'(hit.node * 2 + 1);
          lo[ax] = split;
          hit.depth = hit.depth + 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v < longint'(C_NEG)) return C_NEG;
    if (v > longint'(C_POS)) return C_POS;
    return coord_t'(v[CoordW-1:0]);
  endfunction

  // Mostly small boxes around a point inside the world, some noise and inverted boxes
  function automatic box_t make_box(bit idle_ok);
    box_t            b;
    int unsigned     kind;
    longint          r_lo;
    longint          r_hi;
    longint          c;
    longint          ext_lo;
    longint          ext_hi;
    longint unsigned rnd;
    logic [CoordW-1:0] t;
    kind = $urandom_range(0, 19);
    for (int a = 0; a < 3; a++) begin
      if (kind < 3) begin
        b.mn[a] = $urandom();
        b.mx[a] = $urandom();
      end else begin
        r_lo = world_lo[a];
        r_hi = world_hi[a];
        if (r_lo > r_hi) begin
          c = r_lo;
          r_lo = r_hi;
          r_hi = c;
        end
        rnd = {$urandom(), $urandom()};
        c = r_lo + longint'(rnd % $unsigned(r_hi - r_lo + 1));
        ext_lo = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom() >> $urandom_range(6, 31));
        ext_hi = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom() >> $urandom_range(6, 31));
        b.mn[a] = clamp_coord(c - ext_lo);
        b.mx[a] = clamp_coord(c + ext_hi);
        if (kind == 3) begin
          t = b.mn[a];
          b.mn[a] = b.mx[a];
          b.mx[a] = t;
        end
      end
    end
    b.idle_ok = idle_ok;
    return b;
  endfunction

  task automatic queue_box(box_t b);
    pending_boxes.push_back(b);
    boxes_issued++;
  endtask

  task automatic queue_corners(coord_t lx, coord_t ly, coord_t lz,
                               coord_t hx, coord_t hy, coord_t hz);
    box_t b;
    b.mn[0] = lx;
    b.mn[1] = ly;
    b.mn[2] = lz;
    b.mx[0] = hx;
    b.mx[1] = hy;
    b.mx[2] = hz;
    b.idle_ok = 1'b0;
    queue_box(b);
  endtask

  // Random boxes in chunks that idle or run back to back; the last quiet_tail never idle
  task automatic queue_random(int count, int quiet_tail);
    bit chunk_idle;
    chunk_idle = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) chunk_idle = ($urandom_range(0, 3) != 0);
      queue_box(make_box(chunk_idle && (i < count - quiet_tail)));
    end
  endtask

  task automatic write_world_reg(cfg_idx_t idx, coord_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx <= REG_WORLD_MIN_Z) world_lo[idx] = val;
    else world_hi[idx - REG_WORLD_MAX_X] = val;
  endtask

  task automatic set_world(coord_t lx, coord_t ly, coord_t lz,
                           coord_t hx, coord_t hy, coord_t hz);
    write_world_reg(REG_WORLD_MIN_X, lx);
    write_world_reg(REG_WORLD_MIN_Y, ly);
    write_world_reg(REG_WORLD_MIN_Z, lz);
    write_world_reg(REG_WORLD_MAX_X, hx);
    write_world_reg(REG_WORLD_MAX_Y, hy);
    write_world_reg(REG_WORLD_MAX_Z, hz);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Every queued box has been answered, so the pipeline is empty
  task automatic wait_drained();
    while (hits_checked != boxes_issued) @(posedge clk);
  endtask

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Input driver: record the prediction on each transfer, then present the next box
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_hits.push_back(walk_tree(cur_box));
      if (in_valid && in_stall) begin
        // hold the stalled box
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_boxes.size() != 0) begin
        if (pending_boxes[0].idle_ok && !gap_done && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          gap_done = 1'b1;
          in_valid <= 1'b0;
        end else begin
          gap_done = 1'b0;
          cur_box = pending_boxes.pop_front();
          idle_phase = cur_box.idle_ok;
          in_valid     <= 1'b1;
          in_box_min_x <= cur_box.mn[0];
          in_box_min_y <= cur_box.mn[1];
          in_box_min_z <= cur_box.mn[2];
          in_box_max_x <= cur_box.mx[0];
          in_box_max_y <= cur_box.mx[1];
          in_box_max_z <= cur_box.mx[2];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and stall generator
  always @(posedge clk) begin
    node_hit_t hit;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          flag_mismatch($sformatf("result node %0d depth %0d with nothing expected",
                                  out_node_index, out_node_depth));
        end else begin
          hit = expected_hits.pop_front();
          if (out_node_index !== hit.node)
            flag_mismatch($sformatf("node_index %0d, expected %0d", out_node_index, hit.node));
          if (out_node_depth !== hit.depth)
            flag_mismatch($sformatf("node_depth %0d, expected %0d", out_node_depth, hit.depth));
          hits_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_phase && !stall_done && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        stall_done = 1'b1;
        out_stall <= 1'b1;
      end else begin
        stall_done = 1'b0;
        out_stall <= 1'b0;
      end
    end
  end

  // Phases: reset bounds, full range with corner boxes, small, inverted, saturated, random
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_random(120, 0);
    wait_drained();

    set_world(C_NEG, C_NEG, C_NEG, C_POS, C_POS, C_POS);
    queue_corners('0, '0, '0, '0, '0, '0);
    queue_corners(C_NEG, C_NEG, C_NEG, C_NEG, C_NEG, C_NEG);
    queue_corners(C_POS, C_POS, C_POS, C_POS, C_POS, C_POS);
    queue_corners(C_NEG, C_NEG, C_NEG, C_POS, C_POS, C_POS);
    queue_corners(C_POS, C_POS, C_POS, C_NEG, C_NEG, C_NEG);
    // root split on x sits at -1: max on it goes low, min on it goes high
    queue_corners(-1, '0, '0, -1, '0, '0);
    queue_corners(-1, '0, '0, '0, '0, '0);
    queue_corners(-2, '0, '0, '0, '0, '0);
    // straddle on y at level 1, on z at level 6
    queue_corners(100, -2, '0, 101, '0, '0);
    queue_corners(100, 100, -2, 101, 101, '0);
    // inverted box on x
    queue_corners(10, 7, 7, 5, 7, 7);
    queue_corners(C_NEG, '0, C_NEG, -1, C_POS, C_POS);
    queue_random(200, 0);
    wait_drained();

    set_world(0, -8, 3, 15, 7, 10);
    queue_random(150, 0);
    wait_drained();

    // inverted world bounds
    set_world(1000, 50, C_POS, -1000, -50, C_NEG);
    queue_random(120, 0);
    wait_drained();

    set_world(C_POS, C_NEG, C_NEG, C_POS, C_NEG, C_POS);
    queue_random(100, 0);
    wait_drained();

    for (int k = 0; k < 2; k++) begin
      set_world($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      queue_random(150, 0);
      wait_drained();
    end

    set_world(C_NEG, C_NEG, C_NEG, C_POS, C_POS, C_POS);
    queue_random(160, 100);
    wait_drained();

    repeat (NUM_LEVELS + 4) @(posedge clk);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/btbox_pkg.sv
rtl/core/btbox_level.sv
rtl/core/bisection_tree_box_node_lookup.sv
tb/sv/bisection_tree_box_node_lookup_test.sv
